/* hdl/dpfc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, sizes and codes of the demand page fault classifier.
// Depends on nothing; every other file but dpfc_ram imports it.
package dpfc_pkg;

  localparam int MAX_SEGMENTS      = 8;
  localparam int PAGES_PER_SEGMENT = 256;
  localparam int ADDR_BITS         = 32;

  localparam int SEG_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int PG_IDX_W = (PAGES_PER_SEGMENT > 1) ? $clog2(PAGES_PER_SEGMENT) : 1;
  localparam int PAGE_W   = 20;
  localparam int COPY_W   = 17;

  localparam logic [PAGE_W-1:0] PAGE_LIMIT = PAGE_W'(PAGES_PER_SEGMENT);

  localparam logic [4:0] MIN_SHIFT = 5'd12;
  localparam logic [4:0] MAX_SHIFT = 5'd16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT  = 1'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FAULT = 1'b1;

  localparam logic [2:0] ACT_MAP       = 3'd0;
  localparam logic [2:0] ACT_NO_SEG    = 3'd1;
  localparam logic [2:0] ACT_MAPPED    = 3'd2;
  localparam logic [2:0] ACT_UNTRACKED = 3'd3;
  localparam logic [2:0] ACT_LOAD_ACK  = 3'd4;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic                 op;
    logic [2:0]           seg_index;
    logic [ADDR_BITS-1:0] seg_base;
    logic [31:0]          seg_mem_size;
    logic [31:0]          seg_file_size;
    logic [31:0]          seg_file_offset;
    logic [2:0]           seg_perm;
    logic [ADDR_BITS-1:0] fault_addr;
  } dpfc_in_t;

  typedef struct packed {
    logic [2:0]           action;
    logic [2:0]           hit_segment;
    logic [PAGE_W-1:0]    page_number;
    logic [ADDR_BITS-1:0] map_address;
    logic [31:0]          file_position;
    logic [COPY_W-1:0]    copy_bytes;
    logic [2:0]           page_perm;
  } dpfc_out_t;

  typedef struct packed {
    logic                 is_load;
    logic                 load_ok;
    logic [2:0]           seg_index;
    logic [ADDR_BITS-1:0] seg_base;
    logic [31:0]          seg_mem_size;
    logic [31:0]          seg_file_size;
    logic [31:0]          seg_file_offset;
    logic [2:0]           seg_perm;
    logic [ADDR_BITS-1:0] fault_addr;
  } dpfc_cmd_t;

endpackage

/* hdl/dpfc_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module dpfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* hdl/dpfc_front.sv */
`timescale 1ns / 1ps
// Front end: takes input beats, decodes them into commands for the queue.
// Depends on dpfc_pkg.
module dpfc_front
  import dpfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dpfc_in_t  in_data,
  output logic      push_valid,
  input  logic      push_ready,
  output dpfc_cmd_t push_cmd
);

  dpfc_cmd_t cmd_r;
  logic      cmd_valid_r;
  logic      accept;

  assign in_stall   = cmd_valid_r && !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push_valid = cmd_valid_r;
  assign push_cmd   = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (accept) begin
      cmd_valid_r <= 1'b1;
    end else if (push_ready) begin
      cmd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.is_load         <= (in_data.op == OP_LOAD);
      cmd_r.load_ok         <= (int'(in_data.seg_index) < MAX_SEGMENTS);
      cmd_r.seg_index       <= in_data.seg_index;
      cmd_r.seg_base        <= in_data.seg_base;
      cmd_r.seg_mem_size    <= in_data.seg_mem_size;
      cmd_r.seg_file_size   <= in_data.seg_file_size;
      cmd_r.seg_file_offset <= in_data.seg_file_offset;
      cmd_r.seg_perm        <= in_data.seg_perm;
      cmd_r.fault_addr      <= in_data.fault_addr;
    end
  end

endmodule

/* hdl/dpfc_queue.sv */
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on dpfc_pkg.
module dpfc_queue
  import dpfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  dpfc_cmd_t push_cmd,
  output logic      pop_valid,
  input  logic      pop_ready,
  output dpfc_cmd_t pop_cmd
);

  dpfc_cmd_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_CNT_W-1:0]  count_r;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hdl/dpfc_back.sv */
`timescale 1ns / 1ps
// Back end: segment table, page bitmap RAM, fault sequencer, result register.
// Depends on dpfc_pkg and dpfc_ram.
module dpfc_back
  import dpfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [4:0]       page_shift,
  input  logic [3:0]       segment_count,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  dpfc_cmd_t        pop_cmd,
  output logic             out_valid,
  input  logic             out_stall,
  output dpfc_out_t        out_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_MAP    = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0]           state_r;
  logic [2:0]           state_nxt;

  logic [ADDR_BITS-1:0] base_r     [MAX_SEGMENTS];
  logic [31:0]          mem_size_r [MAX_SEGMENTS];
  logic [31:0]          fsize_r    [MAX_SEGMENTS];
  logic [31:0]          offset_r   [MAX_SEGMENTS];
  logic [2:0]           perm_r     [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] row_vld_r;

  dpfc_cmd_t            cur_r;
  logic                 found_r;
  logic [SEG_W-1:0]     hit_r;
  logic [ADDR_BITS-1:0] rel_r;
  logic [PAGE_W-1:0]    page_r;
  logic [ADDR_BITS-1:0] start_r;
  dpfc_out_t            res_r;
  dpfc_out_t            out_r;
  logic                 out_valid_r;

  logic [4:0]           shift_eff;
  logic                 found_c;
  logic [SEG_W-1:0]     hit_c;
  logic [ADDR_BITS-1:0] rel_c;
  logic [PAGE_W-1:0]    page_c;
  logic                 untracked_c;
  logic [PAGES_PER_SEGMENT-1:0] rd_row;
  logic [PAGES_PER_SEGMENT-1:0] old_row;
  logic [PAGES_PER_SEGMENT-1:0] bit_mask;
  logic                 already_c;
  logic                 ram_we;
  logic [ADDR_BITS-1:0] start_c;
  logic [COPY_W-1:0]    psize_c;
  logic [31:0]          diff_c;
  logic [COPY_W-1:0]    copy_c;
  logic [SEG_W-1:0]     idx_ext;
  logic                 slot_free;
  logic                 take_cmd;
  dpfc_out_t            load_res;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pop_ready = (state_r == ST_IDLE);
  assign take_cmd  = pop_valid && pop_ready;
  assign slot_free = !out_valid_r || !out_stall;
  assign idx_ext   = SEG_W'(pop_cmd.seg_index);

  always_comb begin
    if (page_shift < MIN_SHIFT) begin
      shift_eff = MIN_SHIFT;
    end else if (page_shift > MAX_SHIFT) begin
      shift_eff = MAX_SHIFT;
    end else begin
      shift_eff = page_shift;
    end
  end

  always_comb begin
    load_res = '0;
    if (pop_cmd.is_load) begin
      load_res.action      = ACT_LOAD_ACK;
      load_res.hit_segment = pop_cmd.seg_index;
    end
  end

  // lowest-numbered hit wins: scan from the top down, later hits overwrite
  always_comb begin
    found_c = 1'b0;
    hit_c   = '0;
    rel_c   = '0;
    for (int s = MAX_SEGMENTS - 1; s >= 0; s--) begin
      if ((s < int'(segment_count)) && (cur_r.fault_addr >= base_r[s]) &&
          ((cur_r.fault_addr - base_r[s]) < mem_size_r[s])) begin
        found_c = 1'b1;
        hit_c   = SEG_W'(s);
        rel_c   = cur_r.fault_addr - base_r[s];
      end
    end
  end

  always_comb begin
    page_c      = PAGE_W'(rel_r >> shift_eff);
    untracked_c = (page_c >= PAGE_LIMIT);
    old_row     = row_vld_r[hit_r] ? rd_row : '0;
    bit_mask    = {{(PAGES_PER_SEGMENT - 1){1'b0}}, 1'b1} << page_c[PG_IDX_W-1:0];
    already_c   = old_row[page_c[PG_IDX_W-1:0]];
    ram_we      = (state_r == ST_CHECK) && found_r && !untracked_c && !already_c;
    start_c     = ADDR_BITS'(page_c) << shift_eff;
    psize_c     = {{(COPY_W - 1){1'b0}}, 1'b1} << shift_eff;
    diff_c      = fsize_r[hit_r] - start_r;
    if (fsize_r[hit_r] <= start_r) begin
      copy_c = '0;
    end else if (diff_c > 32'(psize_c)) begin
      copy_c = psize_c;
    end else begin
      copy_c = diff_c[COPY_W-1:0];
    end
  end

  dpfc_ram #(
    .WIDTH (PAGES_PER_SEGMENT),
    .DEPTH (MAX_SEGMENTS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hit_r),
    .wdata (old_row | bit_mask),
    .raddr (hit_c),
    .rdata (rd_row)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take_cmd) begin
          state_nxt = pop_cmd.is_load ? ST_OUT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = ram_we ? ST_MAP : ST_OUT;
      end
      ST_MAP: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (take_cmd && pop_cmd.is_load && pop_cmd.load_ok) begin
        row_vld_r[idx_ext] <= 1'b0;
      end else if (ram_we) begin
        row_vld_r[hit_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_cmd && pop_cmd.is_load && pop_cmd.load_ok) begin
      base_r[idx_ext]     <= pop_cmd.seg_base;
      mem_size_r[idx_ext] <= pop_cmd.seg_mem_size;
      fsize_r[idx_ext]    <= pop_cmd.seg_file_size;
      offset_r[idx_ext]   <= pop_cmd.seg_file_offset;
      perm_r[idx_ext]     <= pop_cmd.seg_perm;
    end
  end

  always_ff @(posedge clk) begin
    if (take_cmd) begin
      cur_r <= pop_cmd;
      res_r <= load_res;
    end
    if (state_r == ST_SEARCH) begin
      found_r <= found_c;
      hit_r   <= hit_c;
      rel_r   <= rel_c;
    end
    if (state_r == ST_CHECK) begin
      page_r  <= page_c;
      start_r <= start_c;
      if (!found_r) begin
        res_r.action <= ACT_NO_SEG;
      end else begin
        res_r.hit_segment <= 3'(hit_r);
        res_r.page_number <= page_c;
        if (untracked_c) begin
          res_r.action <= ACT_UNTRACKED;
        end else if (already_c) begin
          res_r.action <= ACT_MAPPED;
        end
      end
    end
    if (state_r == ST_MAP) begin
      res_r.action        <= ACT_MAP;
      res_r.page_number   <= page_r;
      res_r.map_address   <= base_r[hit_r] + start_r;
      res_r.file_position <= offset_r[hit_r] + start_r;
      res_r.copy_bytes    <= copy_c;
      res_r.page_perm     <= perm_r[hit_r];
    end
    if (state_r == ST_OUT && slot_free) begin
      out_r <= res_r;
    end
  end

endmodule

/* hdl/demand_page_fault_classifier_core.sv */
`timescale 1ns / 1ps
// Top level of the demand page fault classifier: config registers and wiring.
// Depends on dpfc_pkg, dpfc_front, dpfc_queue, dpfc_back.
//
//   port group | direction | beat
//   in_*       | input     | dpfc_in_t: segment load or fault address
//   out_*      | output    | dpfc_out_t: one result per input beat
//   cfg_*      | input     | write of page_shift (0) or segment_count (1)
//
// A load passes the back-end sequencer as pop, result; a fault as pop,
// search, bitmap read, result, with a map compute step before the result
// when it maps a page; the sequencer handles one command at a time.
// Front register and a 2-entry queue take further beats while it works.
// Reset is synchronous, active low; the page bitmap needs no clearing pass.
// A stalled result holds in the output register; the front keeps accepting
// until the queue fills.
module demand_page_fault_classifier_core
  import dpfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dpfc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dpfc_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [4:0] page_shift_r;
  logic [3:0] seg_count_r;

  logic       push_valid;
  logic       push_ready;
  dpfc_cmd_t  push_cmd;
  logic       pop_valid;
  logic       pop_ready;
  dpfc_cmd_t  pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r <= MIN_SHIFT;
      seg_count_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAGE_SHIFT: begin
          page_shift_r <= cfg_wdata[4:0];
        end
        CFG_SEG_COUNT: begin
          seg_count_r <= cfg_wdata[3:0];
        end
        default: begin
          page_shift_r <= page_shift_r;
        end
      endcase
    end
  end

  dpfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  dpfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  dpfc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .page_shift    (page_shift_r),
    .segment_count (seg_count_r),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_cmd       (pop_cmd),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for demand_page_fault_classifier_core: directed segment
// table and fault rows, then random phases under idling and backpressure.
// Depends on dpfc_pkg and the core; predicts every result in-bench.
module tb_top
  import dpfc_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int          PHASES         = 9;
  localparam int          PHASE_BEATS    = 170;
  localparam int          PRESSURE_BEATS = 40;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    dpfc_in_t               beat;
    bit                     typed;
    dpfc_out_t              want;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  dpfc_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  dpfc_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [31:0]                  seg_base_tbl  [MAX_SEGMENTS];
  logic [31:0]                  seg_len_tbl   [MAX_SEGMENTS];
  logic [31:0]                  seg_fsize_tbl [MAX_SEGMENTS];
  logic [31:0]                  seg_foff_tbl  [MAX_SEGMENTS];
  logic [2:0]                   seg_perm_tbl  [MAX_SEGMENTS];
  bit [PAGES_PER_SEGMENT-1:0]   page_seen     [MAX_SEGMENTS];
  logic [4:0]                   shift_reg = 5'd12;
  logic [3:0]                   count_reg = 4'd0;

  dpfc_out_t   awaited_results[$];
  dpfc_out_t   oldest_result;
  stim_row_t   dir_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int          gap_pct        = 0;
  int          stall_pct      = 0;
  bit          hold_out       = 1'b0;
  bit          hold_done      = 1'b0;

  int ph_shift[PHASES] = '{12, 16, 13, 0, 31, 14, 15, 12, 12};
  int ph_count[PHASES] = '{8, 8, 3, 15, 5, 8, 1, 2, 8};
  int ph_gap  [PHASES] = '{0, 47, 0, 25, 0, 47, 0, 25, 0};
  int ph_stall[PHASES] = '{0, 0, 47, 25, 0, 0, 47, 25, 0};

  demand_page_fault_classifier_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int page_bits();
    if (shift_reg < MIN_SHIFT) return int'(MIN_SHIFT);
    if (shift_reg > MAX_SHIFT) return int'(MAX_SHIFT);
    return int'(shift_reg);
  endfunction

  function automatic dpfc_out_t classify_beat(dpfc_in_t b);
    dpfc_out_t       r;
    int              lim;
    int              sh;
    int              hit;
    longint unsigned rel;
    longint unsigned page;
    longint unsigned start;
    longint unsigned psize;
    longint unsigned fsize;
    longint unsigned copy;
    r = '0;
    if (b.op == OP_LOAD) begin
      seg_base_tbl[b.seg_index]  = b.seg_base;
      seg_len_tbl[b.seg_index]   = b.seg_mem_size;
      seg_fsize_tbl[b.seg_index] = b.seg_file_size;
      seg_foff_tbl[b.seg_index]  = b.seg_file_offset;
      seg_perm_tbl[b.seg_index]  = b.seg_perm;
      page_seen[b.seg_index]     = '0;
      r.action      = ACT_LOAD_ACK;
      r.hit_segment = b.seg_index;
      return r;
    end
    lim = (int'(count_reg) > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(count_reg);
    sh  = page_bits();
    hit = -1;
    for (int s = 0; s < lim; s++) begin
      if (hit < 0 && b.fault_addr >= seg_base_tbl[s] &&
          (b.fault_addr - seg_base_tbl[s]) < seg_len_tbl[s])
        hit = s;
    end
    if (hit < 0) begin
      r.action = ACT_NO_SEG;
      return r;
    end
    rel  = 64'(b.fault_addr - seg_base_tbl[hit]);
    page = rel >> sh;
    r.hit_segment = hit[2:0];
    r.page_number = page[PAGE_W-1:0];
    if (page >= PAGES_PER_SEGMENT) begin
      r.action = ACT_UNTRACKED;
      return r;
    end
    if (page_seen[hit][int'(page)]) begin
      r.action = ACT_MAPPED;
      return r;
    end
    page_seen[hit][int'(page)] = 1'b1;
    start = page << sh;
    psize = 64'd1 << sh;
    fsize = 64'(seg_fsize_tbl[hit]);
    if (fsize <= start) copy = '0;
    else if (fsize - start > psize) copy = psize;
    else copy = fsize - start;
    r.action        = ACT_MAP;
    r.map_address   = seg_base_tbl[hit] + start[31:0];
    r.file_position = seg_foff_tbl[hit] + start[31:0];
    r.copy_bytes    = copy[COPY_W-1:0];
    r.page_perm     = seg_perm_tbl[hit];
    return r;
  endfunction

  function automatic dpfc_in_t rand_beat();
    dpfc_in_t    b;
    int          sh;
    int unsigned s;
    int unsigned pages;
    logic [31:0] off;
    sh = page_bits();
    b.seg_index       = 3'($urandom_range(0, 7));
    b.seg_base        = $urandom;
    b.seg_mem_size    = $urandom;
    b.seg_file_size   = $urandom;
    b.seg_file_offset = $urandom;
    b.seg_perm        = 3'($urandom_range(0, 7));
    b.fault_addr      = $urandom;
    if ($urandom_range(0, 99) < 20) begin
      b.op = OP_LOAD;
      if ($urandom_range(0, 1)) b.seg_base = b.seg_base & ~((32'd1 << sh) - 1);
      case ($urandom_range(0, 9))
        0:       b.seg_mem_size = '0;
        1, 2:    ;
        3, 4, 5: b.seg_mem_size = $urandom_range(1, 300) << sh;
        default: b.seg_mem_size = $urandom_range(1, 32'h0004_0000);
      endcase
      case ($urandom_range(0, 3))
        0:       b.seg_file_size = '0;
        1:       ;
        default: b.seg_file_size = $urandom_range(0, b.seg_mem_size);
      endcase
    end else begin
      b.op = OP_FAULT;
      if ($urandom_range(0, 9) != 0) begin
        s = $urandom_range(0, MAX_SEGMENTS - 1);
        case ($urandom_range(0, 9))
          0:       off = $urandom;
          1, 2:    begin
            pages = $urandom_range(0, 300);
            off   = (pages << sh) + $urandom_range(0, (1 << sh) - 1);
          end
          default: begin
            pages = $urandom_range(0, 7);
            off   = (pages << sh) + $urandom_range(0, (1 << sh) - 1);
          end
        endcase
        b.fault_addr = seg_base_tbl[s] + off;
      end
    end
    return b;
  endfunction

  function automatic stim_row_t load_row(logic [2:0] idx, logic [31:0] base,
                                         logic [31:0] len, logic [31:0] fsize,
                                         logic [31:0] foff, logic [2:0] perm);
    stim_row_t r;
    r.kind                 = ROW_BEAT;
    r.reg_idx              = '0;
    r.reg_val              = '0;
    r.beat                 = '0;
    r.beat.op              = OP_LOAD;
    r.beat.seg_index       = idx;
    r.beat.seg_base        = base;
    r.beat.seg_mem_size    = len;
    r.beat.seg_file_size   = fsize;
    r.beat.seg_file_offset = foff;
    r.beat.seg_perm        = perm;
    r.typed                = 1'b1;
    r.want                 = '0;
    r.want.action          = ACT_LOAD_ACK;
    r.want.hit_segment     = idx;
    return r;
  endfunction

  function automatic stim_row_t fault_row(logic [31:0] addr, bit typed, logic [2:0] act,
                                          logic [2:0] hit, logic [PAGE_W-1:0] page);
    stim_row_t r;
    r.kind             = ROW_BEAT;
    r.reg_idx          = '0;
    r.reg_val          = '0;
    r.beat             = '0;
    r.beat.op          = OP_FAULT;
    r.beat.fault_addr  = addr;
    r.typed            = typed;
    r.want             = '0;
    r.want.action      = act;
    r.want.hit_segment = hit;
    r.want.page_number = page;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    r.beat    = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_beat(input dpfc_in_t b, input bit typed, input dpfc_out_t want);
    dpfc_out_t predicted;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = classify_beat(b);
    awaited_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_PAGE_SHIFT) shift_reg = val;
    else count_reg = val[3:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stall, or one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_out && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("unexpected result, action", 32'(out_data.action), '0);
      end else begin
        oldest_result = awaited_results.pop_front();
        if (out_data.action !== oldest_result.action)
          flag_mismatch("action", 32'(out_data.action), 32'(oldest_result.action));
        if (out_data.hit_segment !== oldest_result.hit_segment)
          flag_mismatch("hit_segment", 32'(out_data.hit_segment),
                        32'(oldest_result.hit_segment));
        if (out_data.page_number !== oldest_result.page_number)
          flag_mismatch("page_number", 32'(out_data.page_number),
                        32'(oldest_result.page_number));
        if (out_data.map_address !== oldest_result.map_address)
          flag_mismatch("map_address", out_data.map_address, oldest_result.map_address);
        if (out_data.file_position !== oldest_result.file_position)
          flag_mismatch("file_position", out_data.file_position, oldest_result.file_position);
        if (out_data.copy_bytes !== oldest_result.copy_bytes)
          flag_mismatch("copy_bytes", 32'(out_data.copy_bytes),
                        32'(oldest_result.copy_bytes));
        if (out_data.page_perm !== oldest_result.page_perm)
          flag_mismatch("page_perm", 32'(out_data.page_perm), 32'(oldest_result.page_perm));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int s = 0; s < MAX_SEGMENTS; s++) page_seen[s] = '0;

    dir_rows.push_back(fault_row(32'h0000_1234, 1'b1, ACT_NO_SEG, 3'd0, '0));
    dir_rows.push_back(load_row(3'd0, 32'h1000_0000, 32'h0010_0000, 32'h0000_2800,
                                32'h0000_0100, 3'd5));
    dir_rows.push_back(load_row(3'd1, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_F000, 3'd7));
    dir_rows.push_back(load_row(3'd2, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                                32'h0000_0000, 3'd0));
    dir_rows.push_back(load_row(3'd3, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000,
                                32'h0000_0000, 3'd3));
    dir_rows.push_back(load_row(3'd4, 32'h1000_0000, 32'h0000_1000, 32'h0000_1000,
                                32'h0000_0000, 3'd1));
    dir_rows.push_back(load_row(3'd5, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001,
                                32'h0000_1234, 3'd6));
    dir_rows.push_back(load_row(3'd6, 32'h8000_0000, 32'h0100_0000, 32'h0080_0000,
                                32'h0000_4000, 3'd2));
    dir_rows.push_back(load_row(3'd7, 32'hC000_0000, 32'h4000_0000, 32'h0001_0000,
                                32'h8000_0000, 3'd4));
    dir_rows.push_back(reg_row(CFG_SEG_COUNT, 5'd8));
    dir_rows.push_back(fault_row(32'h1000_0000, 1'b0, ACT_MAP, 3'd0, '0));
    dir_rows.push_back(fault_row(32'h1000_0FFF, 1'b1, ACT_MAPPED, 3'd0, 20'd0));
    dir_rows.push_back(fault_row(32'h1000_2004, 1'b0, ACT_MAP, 3'd0, '0));
    dir_rows.push_back(fault_row(32'h100F_FFFF, 1'b0, ACT_MAP, 3'd0, '0));
    dir_rows.push_back(fault_row(32'h1010_0000, 1'b1, ACT_UNTRACKED, 3'd3, 20'h10100));
    dir_rows.push_back(fault_row(32'hFFFF_FFFF, 1'b0, ACT_MAP, 3'd0, '0));
    dir_rows.push_back(fault_row(32'h0000_0000, 1'b0, ACT_MAP, 3'd0, '0));
    dir_rows.push_back(fault_row(32'h8000_0000, 1'b0, ACT_MAP, 3'd0, '0));
    dir_rows.push_back(reg_row(CFG_PAGE_SHIFT, 5'd31));
    dir_rows.push_back(fault_row(32'h8001_0000, 1'b0, ACT_MAP, 3'd0, '0));
    dir_rows.push_back(fault_row(32'hC000_0000, 1'b0, ACT_MAP, 3'd0, '0));
    dir_rows.push_back(reg_row(CFG_PAGE_SHIFT, 5'd0));
    dir_rows.push_back(reg_row(CFG_SEG_COUNT, 5'd15));
    dir_rows.push_back(fault_row(32'h8000_1000, 1'b1, ACT_MAPPED, 3'd6, 20'd1));
    dir_rows.push_back(load_row(3'd6, 32'h8000_0000, 32'h0100_0000, 32'h0080_0000,
                                32'h0000_4000, 3'd2));
    dir_rows.push_back(fault_row(32'h8000_1000, 1'b0, ACT_MAP, 3'd0, '0));
    dir_rows.push_back(reg_row(CFG_SEG_COUNT, 5'd1));
    dir_rows.push_back(fault_row(32'h2000_0000, 1'b1, ACT_NO_SEG, 3'd0, '0));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(CFG_PAGE_SHIFT, ph_shift[p][CFG_DATA_W-1:0]);
      @(negedge clk);
      write_reg(CFG_SEG_COUNT, ph_count[p][CFG_DATA_W-1:0]);
      gap_pct   = ph_gap[p];
      stall_pct = ph_stall[p];
      if (p == PHASES - 1) begin
        // hold the result side long enough to back up the input
        @(posedge clk);
        hold_out = 1'b1;
        @(negedge clk);
        repeat (PRESSURE_BEATS) send_beat(rand_beat(), 1'b0, '0);
      end else begin
        repeat (PHASE_BEATS) send_beat(rand_beat(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
hdl/dpfc_pkg.sv
hdl/dpfc_ram.sv
hdl/dpfc_front.sv
hdl/dpfc_queue.sv
hdl/dpfc_back.sv
hdl/demand_page_fault_classifier_core.sv
test/tb_top.sv
